/* hw/rtl/ihdr_pkg.sv */
package ihdr_pkg;

  localparam logic [7:0]  PKT_HEADER = 8'hA5;

  localparam logic [1:0] KIND_REPEAT = 2'd0;
  localparam logic [1:0] KIND_NEW    = 2'd1;
  localparam logic [1:0] KIND_BEAT   = 2'd2;

  localparam logic [2:0] REG_SENSOR_ID  = 3'd0;
  localparam logic [2:0] REG_ACTIVE_HI  = 3'd1;
  localparam logic [2:0] REG_BEAT_PER   = 3'd2;
  localparam logic [2:0] REG_CAL_TIME   = 3'd3;
  localparam logic [2:0] REG_THRESHOLD  = 3'd4;
  localparam logic [2:0] REG_COOLDOWN   = 3'd5;
  localparam logic [2:0] REG_REP_TOTAL  = 3'd6;
  localparam logic [2:0] REG_REP_GAP    = 3'd7;

  // controller to datapath commands
  typedef struct packed {
    logic start;      // latch input item
    logic calc;       // evaluate decisions
    logic div_step;   // one baseline division step
    logic div_done;   // write baseline
    logic commit;     // update state after decisions
    logic emit;       // present a byte
    logic next_byte;  // advance within packet
    logic next_pkt;   // advance to next packet
  } ihdr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cal_tick;
    logic [2:0] pkt_mask;   // repeat, new, beat
    logic last_byte;        // byte index 7
    logic div_last;
  } ihdr_status_t;

endpackage

/* hw/rtl/impact_hit_detector_reporter.sv */
// impact hit detector and packet reporter
//
// input channel s_axis: one sample tick per transfer (time stamp, adc reading,
// contact level). output channel m_axis: packet bytes, one per transfer,
// tlast on each packet's checksum byte; tuser carries the last-of-run flag, packet kind, hit code and led.
// config: write cfg_we with cfg_index / cfg_data while the block is idle.
//
// an item is taken, then evaluated in the next cycle; during calibration a
// restoring divider then runs one quotient bit a cycle for the baseline.
// after that 0 to 3 packets of 8 bytes stream out, one byte per cycle when
// the sink is ready. a quiet tick goes through accept, evaluate and commit;
// a calibration tick adds the divider steps, and each packet adds a pick
// step and its 8 bytes.
// reset clears all timers and flags; the first tick after reset sets the
// calibration start and heartbeat reference. a stalled sink holds the
// current byte steady and tready on the input stays low until the tick's
// last byte has gone.
module impact_hit_detector_reporter #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // time_ms, adc_sample, contact_level, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // packet_byte
  output logic        m_axis_tlast,   // end_of_packet
  output logic [5:0]  m_axis_tuser    // last_of_run, packet_kind, hit_code, led_hit
);
  import ihdr_pkg::*;

  ihdr_cmd_t    cmd;
  ihdr_status_t status;
  logic [2:0]   pkt_sel;
  logic         o_last, o_led;
  logic [1:0]   o_kind, o_hit;

  ihdr_ctrl u_ctrl (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .status, .cmd, .pkt_sel
  );

  // sample field is SAMPLE_BITS wide, taken from the 12-bit field
  logic [SAMPLE_BITS-1:0] smp_in;
  assign smp_in = SAMPLE_BITS'(s_axis_tdata[43:32]);

  ihdr_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_time(s_axis_tdata[31:0]), .in_sample(smp_in), .in_level(s_axis_tdata[44]),
    .cmd, .pkt_sel, .status,
    .out_byte(m_axis_tdata), .out_eop(m_axis_tlast), .out_last(o_last),
    .out_kind(o_kind), .out_hit(o_hit), .out_led(o_led)
  );

  assign m_axis_tuser = {o_led, o_hit, o_kind, o_last};
endmodule

/* hw/rtl/ihdr_ctrl.sv */
module ihdr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  ihdr_pkg::ihdr_status_t status,
  output ihdr_pkg::ihdr_cmd_t   cmd,
  output logic [2:0]            pkt_sel
);
  import ihdr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_SEND = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] pend, pend_next;
  logic [2:0] cur, cur_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= '0;
      cur   <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      cur   <= cur_next;
    end
  end

  assign pkt_sel       = cur;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_SEND);

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cur_next   = cur;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        pend_next = status.pkt_mask;
        state_next = status.cal_tick ? ST_DIV : ST_PICK;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.div_done = 1'b1;
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        // lowest pending packet goes first: repeat, new, beat
        if (pend == 3'b000) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.next_pkt = 1'b1;
          cur_next = pend & (~pend + 3'd1);
          pend_next = pend & (pend - 3'd1);
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        cmd.emit = 1'b1;
        if (m_axis_tready) begin
          cmd.next_byte = 1'b1;
          if (status.last_byte) state_next = ST_PICK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // pend stays internal; only cur leaves as pkt_sel, and the datapath makes its own last check
endmodule

/* hw/rtl/ihdr_dp.sv */
module ihdr_dp #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic [31:0]              in_time,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  input  logic                     in_level,
  input  ihdr_pkg::ihdr_cmd_t      cmd,
  input  logic [2:0]               pkt_sel,
  output ihdr_pkg::ihdr_status_t   status,
  output logic [7:0]               out_byte,
  output logic                     out_eop,
  output logic                     out_last,
  output logic [1:0]               out_kind,
  output logic [1:0]               out_hit,
  output logic                     out_led
);
  import ihdr_pkg::*;

  localparam int unsigned PW = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW = SAMPLE_BITS + PW;
  localparam int unsigned CW = $clog2(SW + 1);

  // configuration registers
  logic [7:0]  sensor_id;
  logic        active_high;
  logic [15:0] beat_period, cal_time, cooldown, rep_gap;
  logic [11:0] threshold;
  logic [4:0]  rep_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_id   <= 8'd0;
      active_high <= 1'b1;
      beat_period <= 16'd50;
      cal_time    <= 16'd500;
      threshold   <= 12'd250;
      cooldown    <= 16'd100;
      rep_total   <= 5'd3;
      rep_gap     <= 16'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSOR_ID: sensor_id   <= cfg_data[7:0];
        REG_ACTIVE_HI: active_high <= cfg_data[0];
        REG_BEAT_PER:  beat_period <= cfg_data;
        REG_CAL_TIME:  cal_time    <= cfg_data;
        REG_THRESHOLD: threshold   <= cfg_data[11:0];
        REG_COOLDOWN:  cooldown    <= cfg_data;
        REG_REP_TOTAL: rep_total   <= cfg_data[4:0];
        REG_REP_GAP:   rep_gap     <= cfg_data;
        default: ;
      endcase
    end
  end

  // window memory
  logic [SAMPLE_BITS-1:0] win_mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] win_old;

  // state
  logic [SW-1:0]          win_sum;
  logic [FW-1:0]          win_fill;
  logic [PW-1:0]          win_pos;
  logic [SAMPLE_BITS-1:0] baseline;
  logic                   started;
  logic [31:0] start_time, last_hit, last_beat, last_rep;
  logic [3:0]  reps_left;
  logic [1:0]  rep_code;
  logic        was_active, was_high;
  logic [7:0]  seq;
  logic        lamp;

  // latched item
  logic [31:0]            now;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   lvl;

  // decisions
  logic       cal, do_rep, do_new, do_beat, high_r, active_r;
  logic [1:0] hit;
  logic       cal_now;
  logic [2:0] mask_now;

  always_comb begin
    logic [31:0] st;
    logic [31:0] lb;
    logic [SAMPLE_BITS:0] lim;
    st = started ? start_time : now;
    lb = started ? last_beat : now;
    lim = {1'b0, baseline} + (SAMPLE_BITS+1)'(threshold);
    cal_now = ((now - st) < {16'd0, cal_time});
    active_r = (lvl == active_high);
    high_r = ({1'b0, smp} > lim);
    do_rep = !cal_now && (reps_left != 4'd0) && ((now - last_rep) >= {16'd0, rep_gap});
    do_new = !cal_now && ((now - last_hit) >= {16'd0, cooldown})
             && ((active_r && !was_active) || (high_r && !was_high));
    do_beat = ((now - lb) >= {16'd0, beat_period});
    mask_now = {do_beat, do_new, do_rep};
  end

  // fill count including the current sample
  logic [FW-1:0] fill_new;
  assign fill_new = (win_fill == FW'(WINDOW_DEPTH)) ? win_fill : win_fill + FW'(1);

  // restoring divider for baseline = sum / fill
  logic [SW-1:0] dq, dr;
  logic [CW-1:0] dcnt;
  logic [SW:0]   dtrial;
  assign dtrial = {dr[SW-1:0], dq[SW-1]} - (SW+1)'(fill_new);

  // packet sequencing
  logic [2:0] bidx;
  logic [7:0] csum;
  logic [1:0] pkt_code, pkt_kind;
  logic       more;
  logic [7:0] cur_byte;

  assign status = '{cal_tick: cal_now, pkt_mask: mask_now, last_byte: (bidx == 3'd7),
                    div_last: (dcnt == CW'(SW - 1))};

  always_comb begin
    unique case (pkt_sel)
      3'b001:  begin pkt_code = rep_code; pkt_kind = KIND_REPEAT; end
      3'b010:  begin pkt_code = hit;      pkt_kind = KIND_NEW;    end
      default: begin pkt_code = 2'd0;     pkt_kind = KIND_BEAT;   end
    endcase
    unique case (bidx)
      3'd0: cur_byte = PKT_HEADER;
      3'd1: cur_byte = sensor_id;
      3'd2: cur_byte = {6'd0, pkt_code};
      3'd3: cur_byte = {7'd0, lvl};
      3'd4: cur_byte = 8'(smp);
      3'd5: cur_byte = 8'({{16{1'b0}}, smp} >> 8);
      3'd6: cur_byte = seq;
      default: cur_byte = csum;
    endcase
  end

  assign out_byte = cur_byte;
  assign out_eop  = status.last_byte;
  assign out_last = status.last_byte && !more;
  assign out_kind = pkt_kind;
  assign out_hit  = hit;
  // led shows the lamp state after this tick while its bytes stream
  assign out_led  = status.pkt_mask[2] ? 1'b0 : ((hit != 2'd0) ? 1'b1 : lamp);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      now <= in_time;
      smp <= in_sample;
      lvl <= in_level;
      win_old <= win_mem[win_pos];
    end
    if (cmd.calc) begin
      cal <= status.cal_tick;
      hit <= do_new ? {high_r, active_r} : 2'd0;
      dq  <= win_sum + SW'(smp) - ((win_fill == FW'(WINDOW_DEPTH)) ? SW'(win_old) : '0);
      dr  <= '0;
      dcnt <= '0;
      if (status.cal_tick) win_mem[win_pos] <= smp;
    end
    if (cmd.div_step) begin
      dcnt <= dcnt + CW'(1);
      if (!dtrial[SW]) dr <= dtrial[SW-1:0];
      else dr <= {dr[SW-2:0], dq[SW-1]};
      dq <= {dq[SW-2:0], !dtrial[SW]};
    end
    if (cmd.next_pkt) begin
      bidx <= 3'd0;
      csum <= PKT_HEADER;
    end
    if (cmd.next_byte && bidx != 3'd7) begin
      bidx <= bidx + 3'd1;
      // header is already in the running sum
      if (bidx != 3'd0) csum <= csum + cur_byte;
    end
  end

  // remaining packets after the current one
  always_comb begin
    unique case (pkt_sel)
      3'b001:  more = hit != 2'd0 || status.pkt_mask[2];
      3'b010:  more = status.pkt_mask[2];
      default: more = 1'b0;
    endcase
  end

  logic [SW-1:0] new_sum;
  assign new_sum = win_sum + SW'(smp) - ((win_fill == FW'(WINDOW_DEPTH)) ? SW'(win_old) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_sum <= '0; win_fill <= '0; win_pos <= '0; baseline <= '0;
      started <= 1'b0; start_time <= '0; last_hit <= '0; last_beat <= '0;
      last_rep <= '0; reps_left <= '0; rep_code <= '0;
      was_active <= 1'b0; was_high <= 1'b0; seq <= '0; lamp <= 1'b0;
    end else begin
      if (cmd.div_done) baseline <= SAMPLE_BITS'({dq[SW-2:0], !dtrial[SW]});
      if (cmd.next_byte && bidx == 3'd7) seq <= seq + 8'd1;
      if (cmd.commit) begin
        if (!started) begin
          started <= 1'b1;
          start_time <= now;
          last_beat <= now;
        end
        if (cal) begin
          win_sum <= new_sum;
          if (win_fill != FW'(WINDOW_DEPTH)) win_fill <= win_fill + FW'(1);
          win_pos <= (win_pos == PW'(WINDOW_DEPTH - 1)) ? '0 : win_pos + PW'(1);
          was_active <= active_r;
          was_high <= 1'b0;
        end else begin
          if (status.pkt_mask[0]) begin
            last_rep <= now;
            reps_left <= reps_left - 4'd1;
          end
          if (hit != 2'd0) begin
            last_hit <= now;
            rep_code <= hit;
            last_rep <= now;
            reps_left <= (rep_total == 5'd0) ? 4'd0 :
                         (rep_total > 5'd16) ? 4'd15 : 4'(rep_total - 5'd1);
            lamp <= 1'b1;
          end
          was_active <= active_r;
          was_high <= high_r;
        end
        if (status.pkt_mask[2]) begin
          last_beat <= now;
          lamp <= 1'b0;
        end
      end
    end
  end
endmodule

/* sim/impact_hit_detector_reporter_tb.sv */
`timescale 1ns / 100ps

module impact_hit_detector_reporter_tb;
  import ihdr_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [11:0] adc;
    logic        level;
  } tick_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       last_run;
    logic [1:0] kind;
    logic [1:0] hit;
    logic       led;
  } pkt_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // time_ms, adc_sample, contact_level, zero fill
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // packet_byte
  logic m_axis_tlast;               // end_of_packet
  logic [5:0] m_axis_tuser;         // last_of_run, packet_kind, hit_code, led_hit

  impact_hit_detector_reporter DUT (.*);

  always #5 clk = ~clk;

  // detector settings mirrored for prediction
  logic [7:0]  m_id;
  logic        m_active_hi;
  logic [15:0] m_beat_per, m_cal_time, m_cooldown, m_gap;
  logic [11:0] m_thresh;
  logic [4:0]  m_rep_total;

  // detector state mirrored for prediction
  logic [11:0] win [DEPTH];
  logic [17:0] win_sum;
  logic [6:0]  win_fill;
  logic [5:0]  win_pos;
  logic [11:0] baseline;
  logic [31:0] t_start, t_hit, t_beat, t_rep;
  logic        started;
  logic [3:0]  reps_left;
  logic [1:0]  rep_code;
  logic        contact_prev, analog_prev;
  logic [7:0]  seq_no;
  logic        lamp;

  tick_t     pending_ticks[$];
  pkt_byte_t expected_bytes[$];
  pkt_byte_t tick_bytes[$];

  int mismatches = 0;
  int stall_hold = 0;       // receiver hold-off request, in cycles
  bit pause_sender = 0;     // sender waits for the expected queue to drain
  int tx_gap = 0, rx_gap = 0;
  int idle_cycles = 0;

  task automatic reset_model();
    m_id = 8'd0; m_active_hi = 1'b1; m_beat_per = 16'd50; m_cal_time = 16'd500;
    m_thresh = 12'd250; m_cooldown = 16'd100; m_rep_total = 5'd3; m_gap = 16'd5;
    win_sum = '0; win_fill = '0; win_pos = '0; baseline = '0;
    t_start = '0; t_hit = '0; t_beat = '0; t_rep = '0; started = 0;
    reps_left = '0; rep_code = '0; contact_prev = 0; analog_prev = 0;
    seq_no = '0; lamp = 0;
  endtask

  task automatic queue_packet(input logic [1:0] code, input logic [1:0] kind,
                              input logic level, input logic [11:0] adc);
    logic [7:0] b [8];
    logic [7:0] sum;
    b[0] = PKT_HEADER; b[1] = m_id; b[2] = {6'd0, code}; b[3] = {7'd0, level};
    b[4] = adc[7:0]; b[5] = {4'd0, adc[11:8]}; b[6] = seq_no;
    seq_no = seq_no + 8'd1;
    sum = '0;
    for (int i = 0; i < 7; i++) sum = sum + b[i];
    b[7] = sum;
    for (int i = 0; i < 8; i++)
      tick_bytes.push_back('{data: b[i], eop: (i == 7), last_run: 1'b0,
                             kind: kind, hit: 2'd0, led: 1'b0});
  endtask

  // works out every packet byte one sample tick produces
  task automatic predict_tick(input tick_t t);
    logic active, high;
    logic [1:0] hit;
    logic [4:0] total;
    logic [12:0] limit;
    active = (t.level == m_active_hi);
    hit = 2'd0;
    tick_bytes.delete();
    if (!started) begin
      started = 1; t_start = t.time_ms; t_beat = t.time_ms;
    end
    if (t.time_ms - t_start < {16'd0, m_cal_time}) begin
      if (win_fill < DEPTH) win_fill = win_fill + 7'd1;
      else win_sum = win_sum - win[win_pos];
      win[win_pos] = t.adc;
      win_sum = win_sum + t.adc;
      win_pos = win_pos + 6'd1;
      baseline = 12'(win_sum / win_fill);
      contact_prev = active;
      analog_prev = 0;
    end else begin
      limit = {1'b0, baseline} + {1'b0, m_thresh};
      high = ({1'b0, t.adc} > limit);
      if (reps_left != 0 && t.time_ms - t_rep >= {16'd0, m_gap}) begin
        queue_packet(rep_code, KIND_REPEAT, t.level, t.adc);
        t_rep = t.time_ms;
        reps_left = reps_left - 4'd1;
      end
      if (t.time_ms - t_hit >= {16'd0, m_cooldown} &&
          ((active && !contact_prev) || (high && !analog_prev))) begin
        total = m_rep_total;
        if (total < 1) total = 1;
        if (total > 16) total = 16;
        hit = {high, active};
        t_hit = t.time_ms;
        rep_code = hit;
        queue_packet(hit, KIND_NEW, t.level, t.adc);
        reps_left = 4'(total - 5'd1);
        t_rep = t.time_ms;
        lamp = 1;
      end
      contact_prev = active;
      analog_prev = high;
    end
    if (t.time_ms - t_beat >= {16'd0, m_beat_per}) begin
      queue_packet(2'd0, KIND_BEAT, t.level, t.adc);
      t_beat = t.time_ms;
      lamp = 0;
    end
    for (int k = 0; k < tick_bytes.size(); k++) begin
      tick_bytes[k].last_run = (k == tick_bytes.size() - 1);
      tick_bytes[k].hit = hit;
      tick_bytes[k].led = lamp;
      expected_bytes.push_back(tick_bytes[k]);
    end
  endtask

  // sender: one tick per transfer, random gaps, honors the drain pause
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick(pending_ticks[0]);
        void'(pending_ticks.pop_front());
        tx_gap <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
        s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid) begin
        if (tx_gap > 0) tx_gap <= tx_gap - 1;
        else if (pending_ticks.size() > 0 &&
                 !(pause_sender && expected_bytes.size() > 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'd0, pending_ticks[0].level, pending_ticks[0].adc,
                           pending_ticks[0].time_ms};
        end
      end
    end
  end

  // receiver: random stalls plus one long requested hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
        m_axis_tready <= (rx_gap == 0);
      end else if (!m_axis_tready) begin
        if (rx_gap > 0) rx_gap = rx_gap - 1;
        m_axis_tready <= (rx_gap == 0);
      end
    end
  end

  // monitor: compare each output transfer with the oldest predicted byte
  always @(posedge clk) begin
    pkt_byte_t got, exp_b;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{data: m_axis_tdata, eop: m_axis_tlast, last_run: m_axis_tuser[0],
              kind: m_axis_tuser[2:1], hit: m_axis_tuser[4:3], led: m_axis_tuser[5]};
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte %p", got);
      end else begin
        exp_b = expected_bytes.pop_front();
        if (got !== exp_b) begin
          mismatches++;
          if (mismatches <= 10) $display("byte mismatch: expected %p, got %p", exp_b, got);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst ||
        (pending_ticks.size() == 0 && expected_bytes.size() == 0) || stall_hold > 0)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      REG_SENSOR_ID: m_id = val[7:0];
      REG_ACTIVE_HI: m_active_hi = val[0];
      REG_BEAT_PER:  m_beat_per = val;
      REG_CAL_TIME:  m_cal_time = val;
      REG_THRESHOLD: m_thresh = val[11:0];
      REG_COOLDOWN:  m_cooldown = val;
      REG_REP_TOTAL: m_rep_total = val[4:0];
      default:       m_gap = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued tick has gone and every byte has come, then settle
  task automatic drain();
    while (pending_ticks.size() > 0 || s_axis_tvalid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic tick_t mk(input logic [31:0] t, input logic [11:0] a,
                               input logic l);
    return '{time_ms: t, adc: a, level: l};
  endfunction

  // random session: quiet samples near quiet_adc, mixed with random readings and random out-of-order time stamps
  task automatic add_session(input int n, input logic [31:0] t0, input int quiet_adc);
    logic [31:0] t;
    t = t0;
    for (int i = 0; i < n; i++) begin
      t = t + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0)
        pending_ticks.push_back(mk($urandom, 12'($urandom_range(0, 4095)),
                                   1'($urandom_range(0, 1))));
      else if ($urandom_range(0, 4) == 0)
        pending_ticks.push_back(mk(t, 12'($urandom_range(0, 4095)),
                                   1'($urandom_range(0, 1))));
      else
        pending_ticks.push_back(mk(t, 12'(quiet_adc + $urandom_range(0, 40)),
                                   $urandom_range(0, 5) == 0));
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: short calibration, field extremes
    write_reg(REG_CAL_TIME, 16'd70);
    write_reg(REG_BEAT_PER, 16'd0);
    for (int i = 0; i < 3; i++) pending_ticks.push_back(mk(32'd10 + i, 12'd100, 1'b0));
    pending_ticks.push_back(mk(32'd200, 12'hFFF, 1'b1));
    pending_ticks.push_back(mk(32'd201, 12'd0, 1'b0));
    pending_ticks.push_back(mk(32'hFFFF_FFFF, 12'hFFF, 1'b1));
    pending_ticks.push_back(mk(32'd5, 12'hABC, 1'b0));
    drain();

    // long receiver hold-off while the sender keeps offering ticks
    write_reg(REG_SENSOR_ID, 16'd255);
    write_reg(REG_ACTIVE_HI, 16'd0);
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_COOLDOWN, 16'd0);
    write_reg(REG_REP_TOTAL, 16'd16);
    write_reg(REG_REP_GAP, 16'd0);
    for (int i = 0; i < 8; i++)
      pending_ticks.push_back(mk(32'd300 + i, (i % 2) ? 12'hFFF : 12'd0, i[0]));
    stall_hold = 400;
    drain();

    // out-of-range repeat totals, threshold maximum
    write_reg(REG_REP_TOTAL, 16'd0);
    write_reg(REG_THRESHOLD, 16'd4095);
    write_reg(REG_BEAT_PER, 16'hFFFF);
    pending_ticks.push_back(mk(32'd400, 12'hFFF, 1'b0));
    pending_ticks.push_back(mk(32'd401, 12'hFFF, 1'b1));
    drain();
    write_reg(REG_REP_TOTAL, 16'd31);
    pending_ticks.push_back(mk(32'd402, 12'hFFF, 1'b1));
    pending_ticks.push_back(mk(32'd403, 12'hFFF, 1'b0));
    drain();

    // random sessions under several settings; sender pauses in the second
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_SENSOR_ID, 16'($urandom_range(0, 255)));
      write_reg(REG_ACTIVE_HI, 16'($urandom_range(0, 1)));
      write_reg(REG_BEAT_PER, (s == 3) ? 16'd1 : 16'($urandom_range(10, 120)));
      write_reg(REG_CAL_TIME, (s == 3) ? 16'hFFFF : 16'($urandom_range(1, 100)));
      write_reg(REG_THRESHOLD, 16'($urandom_range(0, 300)));
      write_reg(REG_COOLDOWN, (s == 0) ? 16'hFFFF : 16'($urandom_range(0, 30)));
      write_reg(REG_REP_TOTAL, 16'($urandom_range(1, 16)));
      write_reg(REG_REP_GAP, (s == 1) ? 16'hFFFF : 16'($urandom_range(0, 6)));
      pause_sender = (s == 1);
      add_session(75, $urandom, $urandom_range(0, 3000));
      drain();
      pause_sender = 0;
    end

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
